// ===== hw/rtl/frt_pkg.sv =====
// Shared types, codes and constants of the flash read-timing trainer.
`timescale 1ns / 1ps
package frt_pkg;

   localparam int MAX_TAP     = 99;
   localparam int MIN_DIVIDER = 1;
   localparam int MAX_DIVIDER = 255;
   localparam int DUMMY_SPAN  = 16;

   localparam logic [29:0] DTR_LIMIT_HZ   = 30'd50000000;
   localparam logic [30:0] ONE_IO_MIN_DIV = 31'd5;
   localparam int          DIV_BITS       = 30;
   localparam logic [3:0]  SEQ_FIRST      = 4'd2;
   localparam logic [3:0]  SEQ_LAST       = 4'd15;

   localparam logic [1:0] KIND_SCAN   = 2'd0;
   localparam logic [1:0] KIND_VERIFY = 2'd1;
   localparam logic [1:0] KIND_SEQ    = 2'd2;
   localparam logic [1:0] KIND_FIN    = 2'd3;

   localparam logic [1:0] STAT_BUSY   = 2'd0;
   localparam logic [1:0] STAT_CAL    = 2'd1;
   localparam logic [1:0] STAT_NOWIN  = 2'd2;
   localparam logic [1:0] STAT_BADCFG = 2'd3;

   localparam logic [1:0] IO_DTR    = 2'd1;
   localparam logic [1:0] IO_SINGLE = 2'd2;

   localparam logic OP_START = 1'b0;

   localparam logic [2:0] REG_SYS_CLOCK  = 3'd0;
   localparam logic [2:0] REG_RATE_LIMIT = 3'd1;
   localparam logic [2:0] REG_MIN_WINDOW = 3'd2;
   localparam logic [2:0] REG_VERIFY_REP = 3'd3;
   localparam logic [2:0] REG_BASE_DUMMY = 3'd4;
   localparam logic [2:0] REG_IO_CLASS   = 3'd5;
   localparam logic [2:0] REG_SEQ_WANTED = 3'd6;
   localparam logic [2:0] REG_LANES_LOG2 = 3'd7;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_SDIV,
      ACT_SEEK,
      ACT_CLK,
      ACT_EMIT
   } act_type;

   typedef struct packed {
      logic accept;
      logic start_fin;
      logic seek_step;
      logic clk_go;
      logic clk_fin;
   } cmd_type;

   typedef struct packed {
      act_type act;
      logic    div_busy;
   } stat_type;

endpackage

// ===== hw/rtl/frt_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module frt_div
   import frt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [DIV_BITS-1:0] num,
   input  logic [DIV_BITS:0]   den,
   output logic [DIV_BITS-1:0] quotient,
   output logic                rem_nz,
   output logic                busy
);

   logic                run_ff, run_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS:0]   rem_ff, rem_in, den_ff, den_in;
   logic [DIV_BITS+1:0] trial;

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      trial  = {rem_ff, quo_ff[DIV_BITS-1]};
      if (go) begin
         run_in = 1'b1;
         cnt_in = 5'(DIV_BITS - 1);
         quo_in = num;
         rem_in = '0;
         den_in = den;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = (DIV_BITS+1)'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_BITS:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign rem_nz   = |rem_ff;
   assign busy     = run_ff;

endmodule

// ===== hw/rtl/frt_datapath.sv =====
// Trainer datapath: settings, search state, result word and the shared divider.
`timescale 1ns / 1ps
module frt_datapath
   import frt_pkg::*;
#(
   parameter int TAP_MAX = MAX_TAP,
   parameter int DIV_MIN = MIN_DIVIDER,
   parameter int DIV_MAX = MAX_DIVIDER,
   parameter int SPAN    = DUMMY_SPAN
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [29:0] csr_data,
   input  logic        req_operation,
   input  logic        req_passed,
   input  cmd_type     cmd,
   output stat_type    st,
   output logic [1:0]  res_kind,
   output logic [7:0]  res_divider,
   output logic [7:0]  res_dummy,
   output logic [6:0]  res_delay,
   output logic [3:0]  res_seq,
   output logic [11:0] res_cpb,
   output logic [1:0]  res_status,
   output logic [6:0]  res_width,
   output logic        res_seqon,
   output logic [28:0] res_flash
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SCAN, PH_VERIFY, PH_SEQSCAN, PH_SEQVERIFY, PH_DONE
   } phase_type;

   logic [29:0] sys_clk_ff, rate_ff;
   logic [6:0]  min_win_ff;
   logic [7:0]  ver_rep_ff, base_dummy_ff;
   logic [1:0]  io_ff, lanes_ff;
   logic        seq_want_ff;

   phase_type   phase_ff, phase_in;
   act_type     act_ff, act_in;
   logic        skip_ff, skip_in;
   logic [7:0]  cur_div_ff, cur_div_in;
   logic [8:0]  cur_dummy_ff, cur_dummy_in, dummy_end_ff, dummy_end_in;
   logic [6:0]  cur_tap_ff, cur_tap_in, run_begin_ff, best_width_ff, best_tap_ff;
   logic        run_open_ff;
   logic [7:0]  win_dummy_ff, verify_done_ff, verify_done_in;
   logic [3:0]  seq_index_ff, seq_index_in, seq_bb_ff, seq_bw_ff;

   logic [1:0]  kind_ff, kind_in, status_ff, status_in;
   logic [7:0]  rdiv_ff, rdiv_in, rdummy_ff, rdummy_in;
   logic [6:0]  rdelay_ff, rdelay_in, rwidth_ff, rwidth_in;
   logic [3:0]  rseq_ff, rseq_in;
   logic        rseqon_ff, rseqon_in;
   logic [11:0] cpb_ff, cpb_in;
   logic [28:0] flash_ff, flash_in;

   logic        div_go, div_busy, div_rem_nz;
   logic [29:0] div_num, div_quo;
   logic [30:0] div_den;

   // Working copies of the state that one step may change several times.
   logic        ro;
   logic [6:0]  rb, bw, bt, pos, last, ws, need;
   logic [7:0]  bd, endp, w, vd;
   logic [3:0]  sbw, sbb, seqc;
   logic [8:0]  cd;
   logic [16:0] base;
   logic [9:0]  dend;
   logic [29:0] limit;
   logic [30:0] q;
   logic        acc, fok, fseq, seek, fail, isseq, fin_bad;
   logic [1:0]  fstat;
   logic        e_load, e_seqon;
   logic [1:0]  e_kind, e_status;
   logic [7:0]  e_div, e_dummy;
   logic [6:0]  e_delay, e_width;
   logic [3:0]  e_seq;
   logic [11:0] cpb_v;

   frt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .num      (div_num),
      .den      (div_den),
      .quotient (div_quo),
      .rem_nz   (div_rem_nz),
      .busy     (div_busy)
   );

   always_comb begin
      phase_in       = phase_ff;
      act_in         = act_ff;
      skip_in        = skip_ff;
      cur_div_in     = cur_div_ff;
      cur_dummy_in   = cur_dummy_ff;
      dummy_end_in   = dummy_end_ff;
      cur_tap_in     = cur_tap_ff;
      verify_done_in = verify_done_ff;
      seq_index_in   = seq_index_ff;
      kind_in        = kind_ff;
      status_in      = status_ff;
      rdiv_in        = rdiv_ff;
      rdummy_in      = rdummy_ff;
      rdelay_in      = rdelay_ff;
      rwidth_in      = rwidth_ff;
      rseq_in        = rseq_ff;
      rseqon_in      = rseqon_ff;
      cpb_in         = cpb_ff;
      flash_in       = flash_ff;
      ro = run_open_ff;   rb = run_begin_ff;
      bw = best_width_ff; bt = best_tap_ff; bd = win_dummy_ff;
      sbw = seq_bw_ff;    sbb = seq_bb_ff;
      acc = 1'b0; fok = 1'b0; fseq = 1'b0; seek = 1'b0; fail = 1'b0;
      fstat = STAT_NOWIN;
      e_load = 1'b0; e_kind = KIND_SCAN; e_div = cur_div_ff; e_dummy = '0;
      e_delay = '0; e_seq = '0; e_status = STAT_BUSY; e_width = '0; e_seqon = 1'b0;
      div_go = 1'b0; div_num = sys_clk_ff; div_den = {22'd0, cur_div_ff, 1'b0};
      isseq = (phase_ff == PH_SEQSCAN);
      pos   = isseq ? {3'd0, seq_index_ff} : cur_tap_ff;
      last  = isseq ? {3'd0, SEQ_LAST} : 7'(TAP_MAX);
      endp = '0; w = '0; ws = '0; cd = '0; vd = '0; base = '0; dend = '0;
      q = '0; seqc = '0; fin_bad = 1'b0; cpb_v = '0;
      limit = (io_ff == IO_DTR && rate_ff > DTR_LIMIT_HZ) ? DTR_LIMIT_HZ : rate_ff;
      need  = (min_win_ff == 7'd0) ? 7'd1 : min_win_ff;

      if (cmd.accept) begin
         act_in = ACT_NONE;
         if (req_operation == OP_START) begin
            if (sys_clk_ff == 30'd0 || limit == 30'd0) begin
               fail = 1'b1; fstat = STAT_BADCFG;
            end else begin
               div_go  = 1'b1;
               div_den = {limit, 1'b0};
               act_in  = ACT_SDIV;
            end
         end else if (phase_ff == PH_SCAN || phase_ff == PH_SEQSCAN) begin
            if (req_passed && !ro) begin
               rb = pos; ro = 1'b1;
            end
            if ((!req_passed || pos == last) && ro) begin
               endp = req_passed ? ({1'b0, pos} + 8'd1) : {1'b0, pos};
               w    = endp - {1'b0, rb};
               ws   = (w > 8'd127) ? 7'd127 : w[6:0];
               if (isseq) begin
                  if (w > {4'd0, sbw}) begin
                     sbw = w[3:0]; sbb = rb[3:0];
                  end
               end else if (ws > bw) begin
                  bw = ws;
                  bd = cur_dummy_ff[7:0];
                  bt = 7'(rb + 7'((w - 8'd1) >> 1));
               end
               ro = 1'b0;
            end
            if (isseq) begin
               if (seq_index_ff < SEQ_LAST) begin
                  seq_index_in = seq_index_ff + 4'd1;
                  e_load = 1'b1; e_kind = KIND_SEQ; e_dummy = bd; e_delay = bt;
                  e_seq = seq_index_ff + 4'd1;
               end else if (sbw == 4'd0) begin
                  fok = 1'b1;
               end else begin
                  verify_done_in = '0;
                  if (ver_rep_ff == 8'd0) begin
                     fok = 1'b1; fseq = 1'b1;
                  end else begin
                     phase_in = PH_SEQVERIFY;
                     e_load = 1'b1; e_kind = KIND_SEQ; e_dummy = bd; e_delay = bt;
                     e_seq = 4'(sbb + ((sbw - 4'd1) >> 1));
                  end
               end
            end else if (cur_tap_ff < 7'(TAP_MAX)) begin
               cur_tap_in = cur_tap_ff + 7'd1;
               e_load = 1'b1; e_kind = KIND_SCAN; e_dummy = cur_dummy_ff[7:0];
               e_delay = cur_tap_ff + 7'd1;
            end else begin
               cd = cur_dummy_ff + 9'd1;
               cur_dummy_in = cd;
               if (cd < dummy_end_ff) begin
                  cur_tap_in = '0; ro = 1'b0;
                  e_load = 1'b1; e_kind = KIND_SCAN; e_dummy = cd[7:0];
               end else if (bw < need) begin
                  seek = 1'b1;
               end else begin
                  verify_done_in = '0;
                  if (ver_rep_ff == 8'd0) begin
                     acc = 1'b1;
                  end else begin
                     phase_in = PH_VERIFY;
                     e_load = 1'b1; e_kind = KIND_VERIFY; e_dummy = bd; e_delay = bt;
                  end
               end
            end
         end else if (phase_ff == PH_VERIFY || phase_ff == PH_SEQVERIFY) begin
            vd = verify_done_ff + 8'd1;
            verify_done_in = vd;
            if (phase_ff == PH_VERIFY) begin
               if (!req_passed) begin
                  seek = 1'b1;
               end else if (vd >= ver_rep_ff) begin
                  acc = 1'b1;
               end else begin
                  e_load = 1'b1; e_kind = KIND_VERIFY; e_dummy = bd; e_delay = bt;
               end
            end else begin
               if (!req_passed) begin
                  fok = 1'b1;
               end else if (vd >= ver_rep_ff) begin
                  fok = 1'b1; fseq = 1'b1;
               end else begin
                  e_load = 1'b1; e_kind = KIND_SEQ; e_dummy = bd; e_delay = bt;
                  e_seq = 4'(sbb + ((sbw - 4'd1) >> 1));
               end
            end
         end
      end

      if (cmd.start_fin) begin
         q = {1'b0, div_quo} + {30'd0, div_rem_nz};
         if (q < 31'(DIV_MIN)) begin
            q = 31'(DIV_MIN);
         end
         if (io_ff == IO_SINGLE && q < ONE_IO_MIN_DIV) begin
            q = ONE_IO_MIN_DIV;
         end
         if (q > 31'(DIV_MAX)) begin
            fail = 1'b1; fstat = STAT_BADCFG;
         end else begin
            cur_div_in = q[7:0];
            skip_in    = 1'b0;
            act_in     = ACT_SEEK;
         end
      end

      if (cmd.seek_step) begin
         base = 17'(base_dummy_ff) * 17'(cur_div_ff) * 17'd2;
         if (skip_ff) begin
            skip_in = 1'b0;
            if (cur_div_ff >= 8'(DIV_MAX)) begin
               fail = 1'b1;
            end else begin
               cur_div_in = cur_div_ff + 8'd1;
            end
         end else if (base + 17'd2 <= 17'd255) begin
            dend = {1'b0, base[8:0]} + 10'(SPAN);
            if (dend > 10'd256) begin
               dend = 10'd256;
            end
            cur_dummy_in = base[8:0] + 9'd2;
            dummy_end_in = dend[8:0];
            cur_tap_in   = '0;
            ro = 1'b0; rb = '0; bw = '0; bd = '0; bt = '0;
            phase_in = PH_SCAN;
            e_load = 1'b1; e_kind = KIND_SCAN; e_dummy = base[7:0] + 8'd2;
         end else if (cur_div_ff >= 8'(DIV_MAX)) begin
            fail = 1'b1;
         end else begin
            cur_div_in = cur_div_ff + 8'd1;
         end
      end

      if (acc) begin
         if (seq_want_ff) begin
            seq_index_in = SEQ_FIRST;
            ro = 1'b0; rb = '0; sbb = '0; sbw = '0;
            phase_in = PH_SEQSCAN;
            e_load = 1'b1; e_kind = KIND_SEQ; e_dummy = bd; e_delay = bt;
            e_seq = SEQ_FIRST;
         end else begin
            fok = 1'b1;
         end
      end
      if (fok) begin
         seqc = (sbw == 4'd0) ? 4'd0 : 4'(sbb + ((sbw - 4'd1) >> 1));
         phase_in = PH_DONE;
         e_load = 1'b1; e_kind = KIND_FIN; e_dummy = bd; e_delay = bt;
         e_seq = fseq ? seqc : 4'd0; e_status = STAT_CAL; e_width = bw; e_seqon = fseq;
      end
      if (fail) begin
         phase_in = PH_DONE;
         e_load = 1'b1; e_kind = KIND_FIN; e_status = fstat;
      end
      if (seek) begin
         skip_in = 1'b1;
         act_in  = ACT_SEEK;
      end

      if (e_load) begin
         fin_bad = (e_kind == KIND_FIN) && (e_status != STAT_CAL);
         cpb_v   = {e_div, 4'd0} >> lanes_ff;
         if (io_ff == IO_DTR) begin
            cpb_v = cpb_v >> 1;
         end
         kind_in   = e_kind;
         status_in = e_status;
         rdiv_in   = fin_bad ? 8'd0 : e_div;
         rdummy_in = fin_bad ? 8'd0 : e_dummy;
         rdelay_in = fin_bad ? 7'd0 : e_delay;
         rseq_in   = fin_bad ? 4'd0 : e_seq;
         rwidth_in = fin_bad ? 7'd0 : e_width;
         rseqon_in = fin_bad ? 1'b0 : e_seqon;
         cpb_in    = fin_bad ? 12'd0 : cpb_v;
         flash_in  = '0;
         act_in    = (fin_bad || e_div == 8'd0) ? ACT_EMIT : ACT_CLK;
      end

      if (cmd.clk_go) begin
         div_go  = 1'b1;
         div_den = {22'd0, rdiv_ff, 1'b0};
      end
      if (cmd.clk_fin) begin
         flash_in = div_quo[28:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_clk_ff     <= '0;
         rate_ff        <= 30'd75000000;
         min_win_ff     <= 7'd8;
         ver_rep_ff     <= 8'd4;
         base_dummy_ff  <= 8'd6;
         io_ff          <= 2'd0;
         seq_want_ff    <= 1'b0;
         lanes_ff       <= 2'd2;
         phase_ff       <= PH_IDLE;
         act_ff         <= ACT_NONE;
         skip_ff        <= 1'b0;
         cur_div_ff     <= '0;
         cur_dummy_ff   <= '0;
         dummy_end_ff   <= '0;
         cur_tap_ff     <= '0;
         run_begin_ff   <= '0;
         run_open_ff    <= 1'b0;
         best_width_ff  <= '0;
         win_dummy_ff   <= '0;
         best_tap_ff    <= '0;
         verify_done_ff <= '0;
         seq_index_ff   <= '0;
         seq_bb_ff      <= '0;
         seq_bw_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SYS_CLOCK:  sys_clk_ff    <= csr_data;
               REG_RATE_LIMIT: rate_ff       <= csr_data;
               REG_MIN_WINDOW: min_win_ff    <= csr_data[6:0];
               REG_VERIFY_REP: ver_rep_ff    <= csr_data[7:0];
               REG_BASE_DUMMY: base_dummy_ff <= csr_data[7:0];
               REG_IO_CLASS:   io_ff         <= csr_data[1:0];
               REG_SEQ_WANTED: seq_want_ff   <= csr_data[0];
               REG_LANES_LOG2: lanes_ff      <= csr_data[1:0];
               default: ;
            endcase
         end
         phase_ff       <= phase_in;
         act_ff         <= act_in;
         skip_ff        <= skip_in;
         cur_div_ff     <= cur_div_in;
         cur_dummy_ff   <= cur_dummy_in;
         dummy_end_ff   <= dummy_end_in;
         cur_tap_ff     <= cur_tap_in;
         run_begin_ff   <= rb;
         run_open_ff    <= ro;
         best_width_ff  <= bw;
         win_dummy_ff   <= bd;
         best_tap_ff    <= bt;
         verify_done_ff <= verify_done_in;
         seq_index_ff   <= seq_index_in;
         seq_bb_ff      <= sbb;
         seq_bw_ff      <= sbw;
      end
      kind_ff   <= kind_in;
      status_ff <= status_in;
      rdiv_ff   <= rdiv_in;
      rdummy_ff <= rdummy_in;
      rdelay_ff <= rdelay_in;
      rwidth_ff <= rwidth_in;
      rseq_ff   <= rseq_in;
      rseqon_ff <= rseqon_in;
      cpb_ff    <= cpb_in;
      flash_ff  <= flash_in;
   end

   assign st.act      = act_ff;
   assign st.div_busy = div_busy;

   assign res_kind    = kind_ff;
   assign res_divider = rdiv_ff;
   assign res_dummy   = rdummy_ff;
   assign res_delay   = rdelay_ff;
   assign res_seq     = rseq_ff;
   assign res_cpb     = cpb_ff;
   assign res_status  = status_ff;
   assign res_width   = rwidth_ff;
   assign res_seqon   = rseqon_ff;
   assign res_flash   = flash_ff;

endmodule

// ===== hw/rtl/frt_ctrl.sv =====
// Trainer controller: sequences each command word through the datapath.
`timescale 1ns / 1ps
module frt_ctrl
   import frt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type st,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid
);

   typedef enum logic [2:0] {
      C_IDLE, C_DISPATCH, C_SDIV, C_SEEK, C_CDIV, C_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd.accept    = (state_ff == C_IDLE) && start;
      cmd.start_fin = (state_ff == C_SDIV) && !st.div_busy;
      cmd.seek_step = (state_ff == C_SEEK);
      cmd.clk_go    = (state_ff == C_DISPATCH) && (st.act == ACT_CLK);
      cmd.clk_fin   = (state_ff == C_CDIV) && !st.div_busy;
      state_in      = state_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) state_in = C_DISPATCH;
         end
         C_DISPATCH: begin
            case (st.act)
               ACT_SDIV: state_in = C_SDIV;
               ACT_SEEK: state_in = C_SEEK;
               ACT_CLK:  state_in = C_CDIV;
               ACT_EMIT: state_in = C_EMIT;
               default:  state_in = C_IDLE;
            endcase
         end
         C_SDIV: begin
            if (!st.div_busy) state_in = C_DISPATCH;
         end
         C_SEEK: state_in = C_DISPATCH;
         C_CDIV: begin
            if (!st.div_busy) state_in = C_EMIT;
         end
         C_EMIT: state_in = C_IDLE;
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != C_IDLE);
   assign rsp_valid = (state_ff == C_EMIT);

endmodule

// ===== hw/rtl/flash_read_timing_trainer.sv =====
// Top level of the flash read-timing trainer.
//
//  channel  ports                        handshake
//  request  req_operation, req_passed    start high while busy low
//  result   rsp_* fields                 rsp_valid, one cycle, no back-pressure
//  config   csr_we, csr_index, csr_data  taken on every edge with csr_we high
//
// A word that yields a probe passes through dispatch, the serial divider that derives the
// flash clock, a step to take its quotient, then the result cycle. A start first derives
// the divider on the same serial divider and then takes the first seek step; each divider
// skipped costs one more seek step. A failed finish skips the clock divider.
// Synchronous reset clears control state and restores register defaults.
// Results cannot be stalled; busy stays high until the result cycle ends.
`timescale 1ns / 1ps
module flash_read_timing_trainer
   import frt_pkg::*;
#(
   parameter int TAP_MAX = MAX_TAP,
   parameter int DIV_MIN = MIN_DIVIDER,
   parameter int DIV_MAX = MAX_DIVIDER,
   parameter int SPAN    = DUMMY_SPAN
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic        req_passed,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [29:0] csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_probe_divider,
   output logic [7:0]  rsp_probe_dummy,
   output logic [6:0]  rsp_probe_delay,
   output logic [3:0]  rsp_probe_seq_cycles,
   output logic [11:0] rsp_cycles_per_byte,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_window_width,
   output logic        rsp_sequential_on,
   output logic [28:0] rsp_flash_clock_hz
);

   cmd_type  cmd;
   stat_type st;

   frt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .st        (st),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   frt_datapath #(
      .TAP_MAX (TAP_MAX),
      .DIV_MIN (DIV_MIN),
      .DIV_MAX (DIV_MAX),
      .SPAN    (SPAN)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_operation (req_operation),
      .req_passed    (req_passed),
      .cmd           (cmd),
      .st            (st),
      .res_kind      (rsp_kind),
      .res_divider   (rsp_probe_divider),
      .res_dummy     (rsp_probe_dummy),
      .res_delay     (rsp_probe_delay),
      .res_seq       (rsp_probe_seq_cycles),
      .res_cpb       (rsp_cycles_per_byte),
      .res_status    (rsp_status),
      .res_width     (rsp_window_width),
      .res_seqon     (rsp_sequential_on),
      .res_flash     (rsp_flash_clock_hz)
   );

`ifndef NO_ASSERTIONS
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while idle");
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_FIN && rsp_status != STAT_CAL) |->
      (rsp_probe_divider == 8'd0 && rsp_flash_clock_hz == 29'd0))
      else $error("failed finish carries data");
   a_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted word not worked on");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the flash read-timing trainer.
`timescale 1ns / 1ps

typedef struct packed {
   logic [1:0]  kind;
   logic [7:0]  divider;
   logic [7:0]  dummy;
   logic [6:0]  delay;
   logic [3:0]  seq_cycles;
   logic [11:0] cyc_byte;
   logic [1:0]  status;
   logic [6:0]  width;
   logic        seq_on;
   logic [28:0] flash_hz;
} probe_word_type;

typedef enum int {
   TR_IDLE,
   TR_SCAN,
   TR_VERIFY,
   TR_SEQSCAN,
   TR_SEQVERIFY,
   TR_DONE
} train_phase_type;

class timing_trainer_board;
   int unsigned sys_hz, rate_hz, min_win, repeats, dummy_base, io_mode, seq_want, lanes;
   train_phase_type phase;
   int unsigned divider, dummy, dummy_stop, tap, run_from, run_open;
   int unsigned best_w, win_dummy, best_tap, verified, seq_pos, seq_from, seq_w;
   probe_word_type pending_words[$];
   probe_word_type last_word;
   int errors;

   function new();
      errors = 0;
      sys_hz = 0; rate_hz = 75000000; min_win = 8; repeats = 4;
      dummy_base = 6; io_mode = 0; seq_want = 0; lanes = 2;
      phase = TR_IDLE;
      divider = 0; dummy = 0; dummy_stop = 0; tap = 0; run_from = 0; run_open = 0;
      best_w = 0; win_dummy = 0; best_tap = 0; verified = 0;
      seq_pos = 0; seq_from = 0; seq_w = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [29:0] val);
      case (idx)
         frt_pkg::REG_SYS_CLOCK:  sys_hz = val;
         frt_pkg::REG_RATE_LIMIT: rate_hz = val;
         frt_pkg::REG_MIN_WINDOW: min_win = val[6:0];
         frt_pkg::REG_VERIFY_REP: repeats = val[7:0];
         frt_pkg::REG_BASE_DUMMY: dummy_base = val[7:0];
         frt_pkg::REG_IO_CLASS:   io_mode = val[1:0];
         frt_pkg::REG_SEQ_WANTED: seq_want = val[0];
         frt_pkg::REG_LANES_LOG2: lanes = val[1:0];
         default: ;
      endcase
   endfunction

   function void emit(logic [1:0] kind, int unsigned div, int unsigned dmy,
                      int unsigned dly, int unsigned seq, logic [1:0] stat,
                      int unsigned w, int unsigned son);
      probe_word_type r;
      int unsigned cpb;
      bit bad;
      bad = (kind == frt_pkg::KIND_FIN) && (stat != frt_pkg::STAT_CAL);
      cpb = (div * 16) >> lanes;
      if (io_mode == frt_pkg::IO_DTR) cpb = cpb >> 1;
      r.kind = kind;
      r.divider = bad ? 8'd0 : div[7:0];
      r.dummy = bad ? 8'd0 : dmy[7:0];
      r.delay = bad ? 7'd0 : dly[6:0];
      r.seq_cycles = bad ? 4'd0 : seq[3:0];
      r.cyc_byte = bad ? 12'd0 : cpb[11:0];
      r.status = stat;
      r.width = bad ? 7'd0 : w[6:0];
      r.seq_on = bad ? 1'b0 : son[0];
      r.flash_hz = (bad || div == 0) ? 29'd0 : 29'(sys_hz / (2 * div));
      pending_words.push_back(r);
      last_word = r;
   endfunction

   function void give_up(logic [1:0] stat);
      phase = TR_DONE;
      emit(frt_pkg::KIND_FIN, 0, 0, 0, 0, stat, 0, 0);
   endfunction

   function int unsigned seq_centre();
      if (seq_w == 0) return 0;
      return (seq_from + (seq_w - 1) / 2) & 4'hF;
   endfunction

   function void calibrated(int unsigned son);
      phase = TR_DONE;
      emit(frt_pkg::KIND_FIN, divider, win_dummy, best_tap, son ? seq_centre() : 0,
           frt_pkg::STAT_CAL, best_w, son);
   endfunction

   // Moves to the first divider (from the current one or the next) whose
   // dummy range starts inside the 8-bit dummy field.
   function void next_divider(bit skip);
      int unsigned base;
      if (skip) begin
         if (divider >= frt_pkg::MAX_DIVIDER) begin
            give_up(frt_pkg::STAT_NOWIN);
            return;
         end
         divider++;
      end
      forever begin
         base = dummy_base * divider * 2;
         if (base + 2 <= 255) begin
            dummy = base + 2;
            dummy_stop = (base + frt_pkg::DUMMY_SPAN > 256) ? 256 : base + frt_pkg::DUMMY_SPAN;
            tap = 0; run_open = 0; run_from = 0;
            best_w = 0; win_dummy = 0; best_tap = 0;
            phase = TR_SCAN;
            emit(frt_pkg::KIND_SCAN, divider, dummy, 0, 0, frt_pkg::STAT_BUSY, 0, 0);
            return;
         end
         if (divider >= frt_pkg::MAX_DIVIDER) begin
            give_up(frt_pkg::STAT_NOWIN);
            return;
         end
         divider++;
      end
   endfunction

   function void window_found();
      if (seq_want) begin
         seq_pos = 2; run_open = 0; run_from = 0; seq_from = 0; seq_w = 0;
         phase = TR_SEQSCAN;
         emit(frt_pkg::KIND_SEQ, divider, win_dummy, best_tap, 2, frt_pkg::STAT_BUSY, 0, 0);
      end else begin
         calibrated(0);
      end
   endfunction

   function void start_training();
      int unsigned lim, den, div;
      lim = rate_hz;
      if (io_mode == frt_pkg::IO_DTR && lim > 50000000) lim = 50000000;
      if (sys_hz == 0 || lim == 0) begin
         give_up(frt_pkg::STAT_BADCFG);
         return;
      end
      den = lim * 2;
      div = sys_hz / den;
      if (sys_hz % den != 0) div++;
      if (div < frt_pkg::MIN_DIVIDER) div = frt_pkg::MIN_DIVIDER;
      if (io_mode == frt_pkg::IO_SINGLE && div < 5) div = 5;
      if (div > frt_pkg::MAX_DIVIDER) begin
         give_up(frt_pkg::STAT_BADCFG);
         return;
      end
      divider = div;
      next_divider(0);
   endfunction

   function void take_word(logic op, logic p);
      bit seq;
      int unsigned pos, last, fin, w, ws, need;
      if (op == frt_pkg::OP_START) begin
         start_training();
         return;
      end
      if (phase == TR_SCAN || phase == TR_SEQSCAN) begin
         seq = (phase == TR_SEQSCAN);
         pos = seq ? seq_pos : tap;
         last = seq ? 15 : frt_pkg::MAX_TAP;
         if (p && !run_open) begin
            run_from = pos;
            run_open = 1;
         end
         if ((!p || pos == last) && run_open) begin
            fin = p ? pos + 1 : pos;
            w = fin - run_from;
            ws = (w > 127) ? 127 : w;
            if (seq) begin
               if (w > seq_w) begin
                  seq_w = w;
                  seq_from = run_from;
               end
            end else if (ws > best_w) begin
               best_w = ws;
               win_dummy = dummy & 8'hFF;
               best_tap = (run_from + (w - 1) / 2) & 7'h7F;
            end
            run_open = 0;
         end
         if (seq) begin
            if (seq_pos < 15) begin
               seq_pos++;
               emit(frt_pkg::KIND_SEQ, divider, win_dummy, best_tap, seq_pos,
                    frt_pkg::STAT_BUSY, 0, 0);
            end else if (seq_w == 0) begin
               calibrated(0);
            end else begin
               verified = 0;
               if (repeats == 0) begin
                  calibrated(1);
               end else begin
                  phase = TR_SEQVERIFY;
                  emit(frt_pkg::KIND_SEQ, divider, win_dummy, best_tap, seq_centre(),
                       frt_pkg::STAT_BUSY, 0, 0);
               end
            end
            return;
         end
         if (tap < frt_pkg::MAX_TAP) begin
            tap++;
            emit(frt_pkg::KIND_SCAN, divider, dummy, tap, 0, frt_pkg::STAT_BUSY, 0, 0);
            return;
         end
         dummy++;
         if (dummy < dummy_stop) begin
            tap = 0;
            run_open = 0;
            emit(frt_pkg::KIND_SCAN, divider, dummy, 0, 0, frt_pkg::STAT_BUSY, 0, 0);
            return;
         end
         need = (min_win == 0) ? 1 : min_win;
         if (best_w < need) begin
            next_divider(1);
            return;
         end
         verified = 0;
         if (repeats == 0) begin
            window_found();
            return;
         end
         phase = TR_VERIFY;
         emit(frt_pkg::KIND_VERIFY, divider, win_dummy, best_tap, 0, frt_pkg::STAT_BUSY, 0, 0);
      end else if (phase == TR_VERIFY) begin
         if (!p) begin
            next_divider(1);
            return;
         end
         verified++;
         if (verified >= repeats) window_found();
         else emit(frt_pkg::KIND_VERIFY, divider, win_dummy, best_tap, 0,
                   frt_pkg::STAT_BUSY, 0, 0);
      end else if (phase == TR_SEQVERIFY) begin
         if (!p) begin
            calibrated(0);
            return;
         end
         verified++;
         if (verified >= repeats) calibrated(1);
         else emit(frt_pkg::KIND_SEQ, divider, win_dummy, best_tap, seq_centre(),
                   frt_pkg::STAT_BUSY, 0, 0);
      end
   endfunction

   function void report(string field, longint unsigned exp, longint unsigned act);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, act);
      errors++;
   endfunction

   function void check_word(probe_word_type got);
      probe_word_type exp;
      if (pending_words.size() == 0) begin
         $display("%0t: unexpected result word %h", $time, got);
         errors++;
         return;
      end
      exp = pending_words.pop_front();
      if (got.kind != exp.kind)
         report("kind", exp.kind, got.kind);
      if (got.divider != exp.divider)
         report("probe_divider", exp.divider, got.divider);
      if (got.dummy != exp.dummy)
         report("probe_dummy", exp.dummy, got.dummy);
      if (got.delay != exp.delay)
         report("probe_delay", exp.delay, got.delay);
      if (got.seq_cycles != exp.seq_cycles)
         report("probe_seq_cycles", exp.seq_cycles, got.seq_cycles);
      if (got.cyc_byte != exp.cyc_byte)
         report("cycles_per_byte", exp.cyc_byte, got.cyc_byte);
      if (got.status != exp.status)
         report("status", exp.status, got.status);
      if (got.width != exp.width)
         report("window_width", exp.width, got.width);
      if (got.seq_on != exp.seq_on)
         report("sequential_on", exp.seq_on, got.seq_on);
      if (got.flash_hz != exp.flash_hz)
         report("flash_clock_hz", exp.flash_hz, got.flash_hz);
   endfunction
endclass

module testbench;
   import frt_pkg::*;

   localparam int STALL_LIMIT = 6000;
   localparam int SETTLE = 700;

   logic        clock, reset, start, busy;
   logic        req_operation, req_passed;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [29:0] csr_data;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_probe_divider, rsp_probe_dummy;
   logic [6:0]  rsp_probe_delay;
   logic [3:0]  rsp_probe_seq_cycles;
   logic [11:0] rsp_cycles_per_byte;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_window_width;
   logic        rsp_sequential_on;
   logic [28:0] rsp_flash_clock_hz;

   timing_trainer_board board;
   int stall_cycles = 0;
   int words_sent;
   bit steady;
   int win_lo, win_hi, seq_lo, seq_hi;

   flash_read_timing_trainer DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_word({rsp_kind, rsp_probe_divider, rsp_probe_dummy, rsp_probe_delay,
                           rsp_probe_seq_cycles, rsp_cycles_per_byte, rsp_status,
                           rsp_window_width, rsp_sequential_on, rsp_flash_clock_hz});
      if (reset || rsp_valid || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Each cycle the driver holds off with some probability, except in steady stretches.
   task automatic pause();
      if (!steady)
         while ($urandom_range(0, 99) < 38) @(negedge clock);
   endtask

   task automatic send(logic op, logic p);
      pause();
      @(negedge clock);
      start = 1;
      req_operation = op;
      req_passed = p;
      do @(posedge clock); while (busy);
      board.take_word(op, p);
      words_sent++;
      @(negedge clock);
      start = 0;
   endtask

   // Registers change only once the trainer has gone quiet.
   task automatic settle();
      while (board.pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [29:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_data = val;
      board.write_reg(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   // The emulated flash passes reads inside a tap window and a cycle window.
   function automatic logic flash_reply();
      probe_word_type w;
      logic ok;
      w = board.last_word;
      case (w.kind)
         KIND_SCAN: ok = (w.delay >= win_lo) && (w.delay <= win_hi);
         KIND_VERIFY: ok = ($urandom_range(0, 99) < 92);
         default: begin
            if (board.phase == TR_SEQVERIFY) ok = ($urandom_range(0, 99) < 92);
            else ok = (w.seq_cycles >= seq_lo) && (w.seq_cycles <= seq_hi);
         end
      endcase
      if ($urandom_range(0, 99) < 3) ok = ~ok;
      return ok;
   endfunction

   task automatic train_session();
      int unsigned div, rate, bd, mw, rep;
      int n;
      settle();
      div = $urandom_range(1, 3);
      rate = $urandom_range(1000000, 50000000);
      bd = 126 / div;
      if ($urandom_range(0, 9) == 0) bd = $urandom_range(0, 255);
      mw = $urandom_range(1, 30);
      case ($urandom_range(0, 9))
         0: mw = 0;
         1: mw = 100;
         2: mw = 127;
         default: ;
      endcase
      rep = $urandom_range(0, 6);
      if ($urandom_range(0, 19) == 0) rep = 255;
      csr_write(REG_SYS_CLOCK, 30'(rate * 2 * div - $urandom_range(0, rate - 1)));
      csr_write(REG_RATE_LIMIT, 30'(rate));
      csr_write(REG_MIN_WINDOW, 30'(mw));
      csr_write(REG_VERIFY_REP, 30'(rep));
      csr_write(REG_BASE_DUMMY, 30'(bd));
      csr_write(REG_IO_CLASS, 30'($urandom_range(0, 3) == 2 ? 3 : $urandom_range(0, 1)));
      csr_write(REG_SEQ_WANTED, 30'($urandom_range(0, 1)));
      csr_write(REG_LANES_LOG2, 30'($urandom_range(0, 3)));
      win_lo = $urandom_range(0, 95);
      win_hi = win_lo + $urandom_range(0, 40);
      seq_lo = $urandom_range(2, 15);
      seq_hi = seq_lo + $urandom_range(0, 6);
      send(OP_START, 1'($urandom_range(0, 1)));
      n = 0;
      while (board.phase != TR_DONE && n < 700 && words_sent < 1300) begin
         if ($urandom_range(0, 199) == 0) send(OP_START, 1'($urandom_range(0, 1)));
         else send(~OP_START, flash_reply());
         n++;
      end
      // A stray probe word after the run has finished must be ignored.
      if ($urandom_range(0, 3) == 0) send(~OP_START, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      board = new();
      words_sent = 0;
      steady = 0;
      reset = 1;
      start = 0;
      req_operation = 0;
      req_passed = 0;
      csr_we = 0;
      csr_index = 0;
      csr_data = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: idle probe, zero system clock, huge divider, DTR cap,
      // one-I/O floor, restart while busy.
      send(~OP_START, 1'b1);
      send(OP_START, 1'b0);
      settle();
      csr_write(REG_SYS_CLOCK, 30'h3FFFFFFF);
      csr_write(REG_RATE_LIMIT, 30'd1);
      send(OP_START, 1'b1);
      settle();
      csr_write(REG_RATE_LIMIT, 30'h3FFFFFFF);
      csr_write(REG_IO_CLASS, 30'(IO_DTR));
      csr_write(REG_LANES_LOG2, 30'd0);
      send(OP_START, 1'b0);
      send(~OP_START, 1'b1);
      send(~OP_START, 1'b0);
      send(~OP_START, 1'b1);
      settle();
      csr_write(REG_SYS_CLOCK, 30'd100000000);
      csr_write(REG_RATE_LIMIT, 30'd75000000);
      csr_write(REG_IO_CLASS, 30'(IO_SINGLE));
      csr_write(REG_LANES_LOG2, 30'd3);
      send(OP_START, 1'b1);
      send(~OP_START, 1'b1);
      send(~OP_START, 1'b1);
      send(OP_START, 1'b0);
      send(~OP_START, 1'b0);
      settle();
      csr_write(REG_BASE_DUMMY, 30'd255);
      send(OP_START, 1'b0);
      send(~OP_START, 1'b1);

      while (words_sent < 1300) begin
         steady = ($urandom_range(0, 5) == 0);
         train_session();
      end
      steady = 0;

      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (board.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// ===== flash_read_timing_trainer.f =====
hw/rtl/frt_pkg.sv
hw/rtl/frt_div.sv
hw/rtl/frt_datapath.sv
hw/rtl/frt_ctrl.sv
hw/rtl/flash_read_timing_trainer.sv
tb/testbench.sv
